// ===== sv/fawc_pkg.sv =====
`default_nettype none
package fawc_pkg;

  localparam int LINES_DEF          = 8;
  localparam int MAX_LINE_BYTES_DEF = 64;
  localparam int ADDR_WIDTH_DEF     = 32;
  localparam int MIN_SHIFT          = 3;

  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_STORE = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_ERROR = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam logic REG_ENABLE     = 1'b0;
  localparam logic REG_LINE_SHIFT = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_BYPASS     = 3'd2,
    ST_FILL_DONE  = 3'd3,
    ST_FILL_FAIL  = 3'd4,
    ST_STORE_DONE = 3'd5,
    ST_STORE_FAIL = 3'd6,
    ST_ACCEPTED   = 3'd7
  } status_t;

  // outcome of one item, carried alongside the line store read
  typedef struct packed {
    status_t     status;
    logic        need_data;
    logic [2:0]  byte_off;
    logic [3:0]  size;
    logic [31:0] refill_base;
    logic        lo_odd;
    logic        filled0;
    logic        filled1;
    logic        fwd0;
    logic        fwd1;
    logic [63:0] fwd_data;
  } decision_t;

  function automatic int floor_log2(input int n);
    int r;
    r = 0;
    for (int i = 1; i < 31; i++) begin
      if ((1 << i) <= n) r = i;
    end
    return r;
  endfunction

  function automatic logic [63:0] size_mask(input logic [3:0] sz);
    logic [63:0] m;
    m = 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(sz)) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fawc_bank.sv =====
`default_nettype none
module fawc_bank #(
  parameter int ROWS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [(ROWS>1?$clog2(ROWS):1)-1:0] wrow,
  input  wire logic [7:0]                      be,
  input  wire logic [63:0]                     wdata,
  input  wire logic                            re,
  input  wire logic [(ROWS>1?$clog2(ROWS):1)-1:0] rrow,
  output logic [63:0]                          rdata
);

  logic [63:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < 8; b++) begin
        if (be[b]) mem[wrow][b*8 +: 8] <= wdata[b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[rrow];
  end

endmodule
`default_nettype wire

// ===== sv/fawc_ctrl.sv =====
`default_nettype none
module fawc_ctrl #(
  parameter int LINES          = fawc_pkg::LINES_DEF,
  parameter int MAX_LINE_BYTES = fawc_pkg::MAX_LINE_BYTES_DEF,
  parameter int ADDR_WIDTH     = fawc_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [2:0]          cfg_data,
  input  wire logic                go,
  input  wire logic [2:0]          kind,
  input  wire logic [31:0]         addr,
  input  wire logic [3:0]          size,
  input  wire logic [63:0]         data,
  input  wire logic                cacheable,
  input  wire logic                bus_ok,
  input  wire logic [2:0]          fill_index,
  input  wire logic                fill_last,
  output fawc_pkg::decision_t      dec,
  output logic [63:0]              rd_even,
  output logic [63:0]              rd_odd
);

  localparam int WORDS = (MAX_LINE_BYTES / 8 > 0) ? MAX_LINE_BYTES / 8 : 1;
  localparam int HALF  = (WORDS > 1) ? WORDS / 2 : 1;
  localparam int MAXS  = fawc_pkg::floor_log2(MAX_LINE_BYTES);
  localparam int LOFF  = MAXS;
  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW    = 1 << WW;
  localparam int AW    = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int ROWS  = LINES * HALF;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                    cache_enable;
  logic [2:0]              line_shift;
  logic [LINES-1:0]        line_valid, line_valid_next;
  logic [AW-1:0]           line_tag [LINES];
  logic [AW-1:0]           line_tag_next [LINES];
  logic [LW-1:0]           rank [LINES];
  logic [LW-1:0]           rank_next [LINES];
  logic [LW-1:0]           touched [LINES];
  logic [FW-1:0]           filled [LINES];
  logic [FW-1:0]           filled_next [LINES];
  logic                    pending, pending_next;
  logic [LW-1:0]           victim, victim_next;
  logic [LOFF-1:0]         pend_off, pend_off_next;
  logic [3:0]              pend_size, pend_size_next;
  fawc_pkg::decision_t     dec_next;

  logic [3:0]              eff_shift;
  logic [AW:0]             lbytes;
  logic [AW-1:0]           lmask, a, base;
  logic [LOFF-1:0]         off, roff;
  logic [3:0]              rsize;
  logic [9:0]              end_off;
  logic                    size_ok, bypass;
  logic                    hit_any, fill_ok;
  logic [LW-1:0]           hit_idx, pick, rl, tv;
  logic                    do_touch;
  logic [WW-1:0]           w0, w1, fw;
  logic [63:0]             dm, smask;
  logic [7:0]              be8;
  logic [127:0]            pair_d;
  logic [15:0]             pair_be;
  logic [7:0]              be_lo, be_hi;
  logic [AW:0]             acc_end, tag_limit;

  logic                    even_we, odd_we;
  logic [RAW-1:0]          even_wrow, odd_wrow, even_rrow, odd_rrow;
  logic [7:0]              even_be, odd_be;
  logic [63:0]             even_wd, odd_wd;

  function automatic logic [RAW-1:0] row_of(input logic [LW-1:0] ln, input logic [WW-1:0] w);
    return RAW'(int'(ln) * HALF + (int'(w) >> 1));
  endfunction

  always_comb begin
    if (line_shift < 3'(fawc_pkg::MIN_SHIFT)) eff_shift = 4'(fawc_pkg::MIN_SHIFT);
    else if (int'(line_shift) > MAXS) eff_shift = 4'(MAXS);
    else eff_shift = {1'b0, line_shift};
    lbytes  = (AW+1)'(1) << eff_shift;
    lmask   = AW'(lbytes - (AW+1)'(1));
    a       = addr[AW-1:0];
    base    = a & ~lmask;
    off     = LOFF'(a & lmask);
    end_off = 10'(off) + 10'(size);
    size_ok = (size == 4'd1) || (size == 4'd2) || (size == 4'd4) || (size == 4'd8);
    bypass  = !cache_enable || !cacheable || !size_ok || (end_off > 10'(lbytes));
    fill_ok = (4'(fill_index) < 4'(lbytes >> 3)) && (int'(fill_index) < WORDS);
    fw      = WW'(fill_index);
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    pick     = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (line_valid[i] && line_tag[i] == base) begin
        hit_any = 1'b1;
        hit_idx = LW'(i);
      end
    end
    for (int i = LINES - 1; i >= 0; i--) begin
      if (rank[i] == '0) pick = LW'(i);
    end
    for (int i = LINES - 1; i >= 0; i--) begin
      if (!line_valid[i]) pick = LW'(i);
    end
  end

  // read addresses: the pending load for a fill word, else the access itself
  always_comb begin
    if (kind == fawc_pkg::KIND_FILL) begin
      rl    = victim;
      roff  = pend_off;
      rsize = pend_size;
    end else begin
      rl    = hit_idx;
      roff  = off;
      rsize = size;
    end
    w0 = WW'(int'(roff) >> 3);
    w1 = WW'((int'(roff) >> 3) + 1);
    if (w0[0]) begin
      odd_rrow  = row_of(rl, w0);
      even_rrow = row_of(rl, w1);
    end else begin
      even_rrow = row_of(rl, w0);
      odd_rrow  = row_of(rl, w1);
    end
  end

  always_comb begin
    smask   = fawc_pkg::size_mask(size);
    dm      = data & smask;
    pair_d  = {64'd0, dm} << (int'(off[2:0]) * 8);
    for (int b = 0; b < 8; b++) be8[b] = smask[b*8];
    pair_be = {8'd0, be8} << off[2:0];
    be_lo   = pair_be[7:0];
    be_hi   = pair_be[15:8];
    acc_end = {1'b0, a} + (AW+1)'(size);
  end

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      touched[i] = (rank[i] > rank[tv]) ? rank[i] - LW'(1) : rank[i];
    end
    touched[tv] = LW'(LINES - 1);
  end

  always_comb begin
    line_valid_next = line_valid;
    line_tag_next   = line_tag;
    rank_next       = rank;
    filled_next     = filled;
    pending_next    = pending;
    victim_next     = victim;
    pend_off_next   = pend_off;
    pend_size_next  = pend_size;
    tv              = hit_idx;
    do_touch        = 1'b0;
    tag_limit       = '0;
    even_we = 1'b0; odd_we = 1'b0;
    even_wrow = '0; odd_wrow = '0;
    even_be = '0;   odd_be = '0;
    even_wd = '0;   odd_wd = '0;
    dec_next = '0;
    dec_next.status   = fawc_pkg::ST_ACCEPTED;
    dec_next.byte_off = roff[2:0];
    dec_next.size     = rsize;
    dec_next.lo_odd   = w0[0];
    dec_next.filled0  = filled[rl][w0];
    dec_next.filled1  = filled[rl][w1];
    dec_next.fwd_data = data;

    case (kind)
      fawc_pkg::KIND_LOAD, fawc_pkg::KIND_STORE: begin
        pending_next = 1'b0;
        if (kind == fawc_pkg::KIND_LOAD) begin
          if (bypass) begin
            dec_next.status = fawc_pkg::ST_BYPASS;
          end else if (hit_any) begin
            dec_next.status    = fawc_pkg::ST_HIT;
            dec_next.need_data = 1'b1;
            do_touch = 1'b1;
          end else begin
            dec_next.status      = fawc_pkg::ST_MISS;
            dec_next.refill_base = 32'(base);
            line_valid_next[pick] = 1'b0;
            line_tag_next[pick]   = base;
            filled_next[pick]     = '0;
            pending_next   = 1'b1;
            victim_next    = pick;
            pend_off_next  = off;
            pend_size_next = size;
          end
        end else if (bypass) begin
          dec_next.status = bus_ok ? fawc_pkg::ST_STORE_DONE : fawc_pkg::ST_STORE_FAIL;
          if (bus_ok && size != 4'd0) begin
            for (int i = 0; i < LINES; i++) begin
              tag_limit = {1'b0, line_tag[i]} + lbytes;
              if (line_valid[i] && {1'b0, a} < tag_limit && {1'b0, line_tag[i]} < acc_end)
                line_valid_next[i] = 1'b0;
            end
          end
        end else if (!bus_ok) begin
          dec_next.status = fawc_pkg::ST_STORE_FAIL;
        end else begin
          dec_next.status = fawc_pkg::ST_STORE_DONE;
          if (hit_any) begin
            do_touch = 1'b1;
            // a never-written word takes zeros around the stored bytes
            if (be_lo != 8'd0) filled_next[hit_idx][w0] = 1'b1;
            if (be_hi != 8'd0) filled_next[hit_idx][w1] = 1'b1;
            if (w0[0]) begin
              odd_we    = be_lo != 8'd0;
              odd_wrow  = row_of(hit_idx, w0);
              odd_be    = filled[hit_idx][w0] ? be_lo : 8'hFF;
              odd_wd    = pair_d[63:0];
              even_we   = be_hi != 8'd0;
              even_wrow = row_of(hit_idx, w1);
              even_be   = filled[hit_idx][w1] ? be_hi : 8'hFF;
              even_wd   = pair_d[127:64];
            end else begin
              even_we   = be_lo != 8'd0;
              even_wrow = row_of(hit_idx, w0);
              even_be   = filled[hit_idx][w0] ? be_lo : 8'hFF;
              even_wd   = pair_d[63:0];
              odd_we    = be_hi != 8'd0;
              odd_wrow  = row_of(hit_idx, w1);
              odd_be    = filled[hit_idx][w1] ? be_hi : 8'hFF;
              odd_wd    = pair_d[127:64];
            end
          end
        end
      end
      fawc_pkg::KIND_FILL: begin
        if (pending) begin
          if (fill_ok) begin
            filled_next[victim][fw] = 1'b1;
            if (fw[0]) begin
              odd_we = 1'b1; odd_wrow = row_of(victim, fw);
              odd_be = 8'hFF; odd_wd = data;
            end else begin
              even_we = 1'b1; even_wrow = row_of(victim, fw);
              even_be = 8'hFF; even_wd = data;
            end
          end
          if (fill_last) begin
            line_valid_next[victim] = 1'b1;
            tv       = victim;
            do_touch = 1'b1;
            pending_next = 1'b0;
            dec_next.status    = fawc_pkg::ST_FILL_DONE;
            dec_next.need_data = 1'b1;
            dec_next.fwd0 = fill_ok && (fw == w0);
            dec_next.fwd1 = fill_ok && (fw == w1);
          end
        end
      end
      fawc_pkg::KIND_ERROR: begin
        if (pending) begin
          pending_next    = 1'b0;
          dec_next.status = fawc_pkg::ST_FILL_FAIL;
        end
      end
      fawc_pkg::KIND_CLEAR: begin
        line_valid_next = '0;
        for (int i = 0; i < LINES; i++) rank_next[i] = LW'(i);
        pending_next   = 1'b0;
        victim_next    = '0;
        pend_off_next  = '0;
        pend_size_next = '0;
      end
      default: begin
      end
    endcase
    if (do_touch) rank_next = touched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
      line_shift   <= 3'd6;
      line_valid   <= '0;
      for (int i = 0; i < LINES; i++) rank[i] <= LW'(i);
      pending      <= 1'b0;
      victim       <= '0;
      pend_off     <= '0;
      pend_size    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fawc_pkg::REG_ENABLE) begin
        cache_enable <= cfg_data[0];
      end else begin
        line_shift <= cfg_data;
        line_valid <= '0;
        pending    <= 1'b0;
      end
    end else if (go) begin
      line_valid <= line_valid_next;
      rank       <= rank_next;
      pending    <= pending_next;
      victim     <= victim_next;
      pend_off   <= pend_off_next;
      pend_size  <= pend_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && !cfg_we) begin
      line_tag <= line_tag_next;
      filled   <= filled_next;
    end
    if (go) dec <= dec_next;
  end

  fawc_bank #(.ROWS(ROWS)) u_even (
    .clk(clk), .we(go && !cfg_we && even_we), .wrow(even_wrow), .be(even_be),
    .wdata(even_wd), .re(go), .rrow(even_rrow), .rdata(rd_even)
  );

  fawc_bank #(.ROWS(ROWS)) u_odd (
    .clk(clk), .we(go && !cfg_we && odd_we), .wrow(odd_wrow), .be(odd_be),
    .wdata(odd_wd), .re(go), .rrow(odd_rrow), .rdata(rd_odd)
  );

endmodule
`default_nettype wire

// ===== sv/fully_assoc_write_through_cache_unit.sv =====
// path: input register, then the decision stage with the word bank reads, then the output register
// throughput: one item per cycle while out_stall is low; the single-pass decision stage and the two
// word banks (even and odd words, one read and one write each) set that rate
// reset: synchronous; lines invalid, recency order by line index, no refill
// pending, cache enabled with 64-byte lines; the line store is not cleared
`default_nettype none
module fully_assoc_write_through_cache_unit #(
  parameter int LINES          = fawc_pkg::LINES_DEF,
  parameter int MAX_LINE_BYTES = fawc_pkg::MAX_LINE_BYTES_DEF,
  parameter int ADDR_WIDTH     = fawc_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] addr,
  input  wire logic [3:0]  size,
  input  wire logic [63:0] data,
  input  wire logic        cacheable,
  input  wire logic        bus_ok,
  input  wire logic [2:0]  fill_index,
  input  wire logic        fill_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [63:0]      load_data,
  output logic [31:0]      refill_base
);

  logic                 v1, v2, v3;
  logic                 adv2, adv3, take;
  logic [2:0]           r_kind;
  logic [31:0]          r_addr;
  logic [3:0]           r_size;
  logic [63:0]          r_data;
  logic                 r_cacheable, r_bus_ok, r_fill_last;
  logic [2:0]           r_fill_index;
  fawc_pkg::decision_t  dec;
  logic [63:0]          rd_even, rd_odd;
  logic [63:0]          lo, hi, val;
  logic [127:0]         pair;
  fawc_pkg::status_t    o_status;
  logic [63:0]          o_data;
  logic [31:0]          o_base;

  assign adv3     = v2 && (!v3 || !out_stall);
  assign adv2     = v1 && (!v2 || adv3);
  assign in_stall = v1 && !adv2;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take) v1 <= 1'b1;
      else if (adv2) v1 <= 1'b0;
      if (adv2) v2 <= 1'b1;
      else if (adv3) v2 <= 1'b0;
      if (adv3) v3 <= 1'b1;
      else if (!out_stall) v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r_kind       <= kind;
      r_addr       <= addr;
      r_size       <= size;
      r_data       <= data;
      r_cacheable  <= cacheable;
      r_bus_ok     <= bus_ok;
      r_fill_index <= fill_index;
      r_fill_last  <= fill_last;
    end
  end

  fawc_ctrl #(
    .LINES(LINES), .MAX_LINE_BYTES(MAX_LINE_BYTES), .ADDR_WIDTH(ADDR_WIDTH)
  ) u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .go(adv2), .kind(r_kind), .addr(r_addr), .size(r_size), .data(r_data),
    .cacheable(r_cacheable), .bus_ok(r_bus_ok), .fill_index(r_fill_index),
    .fill_last(r_fill_last), .dec(dec), .rd_even(rd_even), .rd_odd(rd_odd)
  );

  // byte alignment of the two words holding the access
  always_comb begin
    if (dec.fwd0) lo = dec.fwd_data;
    else if (dec.filled0) lo = dec.lo_odd ? rd_odd : rd_even;
    else lo = 64'd0;
    if (dec.fwd1) hi = dec.fwd_data;
    else if (dec.filled1) hi = dec.lo_odd ? rd_even : rd_odd;
    else hi = 64'd0;
    pair = {hi, lo} >> (int'(dec.byte_off) * 8);
    val  = pair[63:0] & fawc_pkg::size_mask(dec.size);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      o_status <= dec.status;
      o_data   <= dec.need_data ? val : 64'd0;
      o_base   <= dec.refill_base;
    end
  end

  assign out_valid   = v3;
  assign status      = o_status;
  assign load_data   = o_data;
  assign refill_base = o_base;

  a_hold_stage2: assert property (@(posedge clk) disable iff (rst)
    (v2 && v3 && out_stall) |=> v2)
    else $error("decision stage dropped while output stalled");

  a_miss_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == fawc_pkg::ST_MISS) |-> (load_data == 64'd0))
    else $error("miss result carries load data");

  a_data_kind: assert property (@(posedge clk) disable iff (rst)
    (v2 && dec.need_data) |->
      (dec.status == fawc_pkg::ST_HIT || dec.status == fawc_pkg::ST_FILL_DONE))
    else $error("line data requested for a result without data");

endmodule
`default_nettype wire
